[rtl/lfpd_pkg.sv]
// Package for the line-follow PID motor drive: constants, register indexes,
// controller states and the command and status bundles.
// No dependencies.
package lfpd_pkg;

  localparam int GainW   = 16;
  localparam int SpeedW  = 8;
  localparam int PosW    = 13;
  localparam int EchoW   = 16;
  localparam int SumW    = 32;
  localparam int DeltaW  = 14;
  localparam int ProdW   = GainW + SumW;
  localparam int AccW    = ProdW + 2;
  localparam int DistW   = EchoW + 5;
  localparam int CfgIdxW = 3;
  localparam int FracW   = 12;
  localparam int NumW    = 2 * SpeedW;

  localparam logic [GainW-1:0]  GainPReset  = 16'd410;
  localparam logic [GainW-1:0]  GainIReset  = 16'd0;
  localparam logic [GainW-1:0]  GainDReset  = 16'd0;
  localparam logic [SpeedW-1:0] TopReset    = 8'd240;
  localparam logic [SpeedW-1:0] FloorReset  = 8'd170;

  localparam logic [PosW-1:0]   CenterPos   = 13'd2500;
  localparam logic [PosW-1:0]   PosMax      = 13'd5000;
  localparam logic [SpeedW-1:0] SlowFloor   = 8'd80;

  localparam logic [DistW-1:0]  DistStop    = 21'd5000;
  localparam logic [DistW-1:0]  DistFar     = 21'd10000;
  localparam logic [DistW-1:0]  Dist6       = 21'd6000;
  localparam logic [DistW-1:0]  Dist7       = 21'd7000;
  localparam logic [DistW-1:0]  Dist8       = 21'd8000;
  localparam logic [DistW-1:0]  Dist9       = 21'd9000;

  localparam logic [7:0] Recip5      = 8'd205;
  localparam int         Recip5Shift = 10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_P = 3'd0,
    CFG_GAIN_I = 3'd1,
    CFG_GAIN_D = 3'd2,
    CFG_TOP    = 3'd3,
    CFG_FLOOR  = 3'd4
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_ACC,
    S_CORR,
    S_SPEED,
    S_DIV,
    S_WAIT,
    S_SLOW,
    S_FINAL
  } state_t;

  typedef enum logic [1:0] {
    MUL_P,
    MUL_I,
    MUL_D
  } mul_sel_t;

  typedef enum logic [1:0] {
    BAND_FAR,
    BAND_SLOW,
    BAND_STOP
  } band_t;

  typedef struct packed {
    logic     capture;
    logic     err_upd;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_add;
    logic     corr_en;
    logic     speed_en;
    logic     div_start;
    logic     slow_en;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

[rtl/line_follow_pid_motor_drive.sv]
// Line-follow PID differential drive with an obstacle brake: top level.
// One item at a time: in_stall is high from acceptance until its result is loaded.
// The 16-step restoring dividers of the speed mapping take most of each item's time.
// A result held by out_stall delays the final load and the acceptance of the next item.
// Synchronous reset restores the register defaults and clears the integral and last error.
// Depends on lfpd_pkg, lfpd_ctrl, lfpd_dpath and lfpd_div.
module line_follow_pid_motor_drive import lfpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PosW-1:0]    line_position,
  input  logic [EchoW-1:0]   echo_time_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SpeedW-1:0]  left_duty,
  output logic [SpeedW-1:0]  right_duty,
  output logic               left_forward,
  output logic               right_forward,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [GainW-1:0]   cfg_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      busy;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;

  lfpd_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  lfpd_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_valid      (in_valid),
    .line_position (line_position),
    .echo_time_us  (echo_time_us),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .left_duty     (left_duty),
    .right_duty    (right_duty),
    .left_forward  (left_forward),
    .right_forward (right_forward)
  );

endmodule

[rtl/lfpd_div.sv]
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on lfpd_pkg.
module lfpd_div import lfpd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NumW-1:0]   dividend,
  input  logic [SpeedW-1:0] divisor,
  output logic              done,
  output logic [NumW-1:0]   quotient
);

  logic                      busy;
  logic [$clog2(NumW)-1:0]   cnt;
  logic [SpeedW-1:0]         rem;
  logic [NumW-1:0]           quo;
  logic [SpeedW-1:0]         dvs;
  logic [SpeedW:0]           shifted;
  logic [SpeedW:0]           diff;
  logic                      fits;

  assign shifted  = {rem, quo[NumW-1]};
  assign fits     = shifted >= {1'b0, dvs};
  assign diff     = shifted - {1'b0, dvs};
  assign done     = busy && (cnt == '0);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '1;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[SpeedW-1:0] : shifted[SpeedW-1:0];
      quo <= {quo[NumW-2:0], fits};
    end
  end

endmodule

[rtl/lfpd_ctrl.sv]
// Controller state machine that sequences one item through the datapath.
// Depends on lfpd_pkg.
module lfpd_ctrl import lfpd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd,
  output logic      busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (sts.in_valid) state_next = S_ERR;
      S_ERR:   state_next = S_MUL_P;
      S_MUL_P: state_next = S_MUL_I;
      S_MUL_I: state_next = S_MUL_D;
      S_MUL_D: state_next = S_ACC;
      S_ACC:   state_next = S_CORR;
      S_CORR:  state_next = S_SPEED;
      S_SPEED: state_next = S_DIV;
      S_DIV:   state_next = S_WAIT;
      S_WAIT:  if (sts.div_done) state_next = S_SLOW;
      S_SLOW:  state_next = S_FINAL;
      S_FINAL: if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    cmd.mul_sel = MUL_P;
    busy = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = sts.in_valid;
      end
      S_ERR:   cmd.err_upd = 1'b1;
      S_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_P;
      end
      S_MUL_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_I;
        cmd.acc_add = 1'b1;
      end
      S_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_D;
        cmd.acc_add = 1'b1;
      end
      S_ACC:   cmd.acc_add   = 1'b1;
      S_CORR:  cmd.corr_en   = 1'b1;
      S_SPEED: cmd.speed_en  = 1'b1;
      S_DIV:   cmd.div_start = 1'b1;
      S_WAIT:  ;
      S_SLOW:  cmd.slow_en   = 1'b1;
      S_FINAL: cmd.out_load  = sts.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/lfpd_dpath.sv]
// Datapath: configuration registers, PID state, the shared multiplier,
// two dividers for the speed mapping, the distance bands and the output register.
// Depends on lfpd_pkg and lfpd_div.
module lfpd_dpath import lfpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  output ctrl_sts_t          sts,
  input  logic               in_valid,
  input  logic [PosW-1:0]    line_position,
  input  logic [EchoW-1:0]   echo_time_us,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [GainW-1:0]   cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SpeedW-1:0]  left_duty,
  output logic [SpeedW-1:0]  right_duty,
  output logic               left_forward,
  output logic               right_forward
);

  logic signed [GainW-1:0]  gain_p, gain_i, gain_d;
  logic [SpeedW-1:0]        top_speed, floor_speed;
  logic signed [SumW-1:0]   error_sum;
  logic signed [PosW-1:0]   previous_error;

  logic [PosW-1:0]          pos;
  logic [EchoW-1:0]         echo;
  logic signed [PosW-1:0]   err_cur;
  logic signed [DeltaW-1:0] delta;
  band_t                    band;
  logic [2:0]               cw;
  logic signed [ProdW-1:0]  prod;
  logic signed [AccW-1:0]   acc;
  logic signed [SpeedW:0]   corr;
  logic [NumW-1:0]          num_l, num_r;
  logic [SpeedW-1:0]        mapped_l, mapped_r;
  logic signed [11:0]       prod5_l, prod5_r;

  logic [PosW-1:0]          pos_c;
  logic signed [PosW:0]     err_w;
  logic signed [SumW:0]     sum_w;
  logic signed [SumW-1:0]   sum_next;
  logic [DistW-1:0]         echo_x17;
  logic signed [GainW-1:0]  mul_a;
  logic signed [SumW-1:0]   mul_b;
  logic signed [AccW-1:0]   acc_adj;
  logic signed [AccW-1:0]   corr_full;
  logic signed [AccW-1:0]   top_ext;
  logic [SpeedW-1:0]        flo_c;
  logic [SpeedW-1:0]        rng;
  logic signed [SpeedW+1:0] sum_l, sum_r;
  logic [SpeedW-1:0]        s_l, s_r;
  logic                     done_l, done_r;
  logic [NumW-1:0]          quo_l, quo_r;
  logic [SpeedW-1:0]        map_l, map_r;
  logic [SpeedW:0]          fin_l, fin_r;
  logic [SpeedW-1:0]        duty_l, duty_r;

  function automatic logic [SpeedW-1:0] clamp_top(input logic signed [SpeedW+1:0] v,
                                                  input logic [SpeedW-1:0] top);
    logic signed [SpeedW+1:0] t;
    t = $signed({2'b00, top});
    return (v > t) ? top : v[SpeedW-1:0];
  endfunction

  function automatic logic signed [11:0] slow_prod(input logic [SpeedW-1:0] m,
                                                    input logic [2:0] c);
    logic signed [SpeedW+1:0] d;
    d = $signed({2'b00, m}) - $signed({2'b00, SlowFloor});
    return $signed({1'b0, c}) * d;
  endfunction

  function automatic logic [SpeedW:0] slow_speed(input logic signed [11:0] p);
    logic [9:0]  mag;
    logic [17:0] qm;
    logic [7:0]  q;
    mag = p[11] ? 10'(-p) : p[9:0];
    qm  = mag * Recip5;
    q   = qm[Recip5Shift+7:Recip5Shift];
    return p[11] ? ({1'b0, SlowFloor} - {1'b0, q}) : ({1'b0, SlowFloor} + {1'b0, q});
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p      <= GainPReset;
      gain_i      <= GainIReset;
      gain_d      <= GainDReset;
      top_speed   <= TopReset;
      floor_speed <= FloorReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_P: gain_p      <= cfg_data;
        CFG_GAIN_I: gain_i      <= cfg_data;
        CFG_GAIN_D: gain_d      <= cfg_data;
        CFG_TOP:    top_speed   <= cfg_data[SpeedW-1:0];
        CFG_FLOOR:  floor_speed <= cfg_data[SpeedW-1:0];
        default:    ;
      endcase
    end
  end

  assign pos_c    = (pos > PosMax) ? PosMax : pos;
  assign err_w    = $signed({1'b0, pos_c}) - $signed({1'b0, CenterPos});
  assign sum_w    = $signed({error_sum[SumW-1], error_sum}) + (SumW+1)'(err_w);
  assign echo_x17 = {1'b0, echo, 4'b0000} + {5'b00000, echo};

  always_comb begin
    if (!sum_w[SumW] && sum_w[SumW-1]) begin
      sum_next = {1'b0, {(SumW-1){1'b1}}};
    end else if (sum_w[SumW] && !sum_w[SumW-1]) begin
      sum_next = {1'b1, {(SumW-1){1'b0}}};
    end else begin
      sum_next = sum_w[SumW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (cmd.err_upd) begin
      error_sum      <= sum_next;
      previous_error <= err_w[PosW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos  <= line_position;
      echo <= echo_time_us;
    end
    if (cmd.err_upd) begin
      err_cur <= err_w[PosW-1:0];
      delta   <= DeltaW'(err_w) - DeltaW'(previous_error);
      if (echo_x17 < DistStop) begin
        band <= BAND_STOP;
      end else if (echo_x17 < DistFar) begin
        band <= BAND_SLOW;
      end else begin
        band <= BAND_FAR;
      end
      if (echo_x17 >= Dist9) begin
        cw <= 3'd4;
      end else if (echo_x17 >= Dist8) begin
        cw <= 3'd3;
      end else if (echo_x17 >= Dist7) begin
        cw <= 3'd2;
      end else if (echo_x17 >= Dist6) begin
        cw <= 3'd1;
      end else begin
        cw <= 3'd0;
      end
    end
  end

  always_comb begin
    mul_a = gain_p;
    mul_b = SumW'(err_cur);
    case (cmd.mul_sel)
      MUL_I: begin
        mul_a = gain_i;
        mul_b = error_sum;
      end
      MUL_D: begin
        mul_a = gain_d;
        mul_b = SumW'(delta);
      end
      default: begin
        mul_a = gain_p;
        mul_b = SumW'(err_cur);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.err_upd) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + AccW'(prod);
    end
  end

  assign top_ext   = $signed({{(AccW-SpeedW){1'b0}}, top_speed});
  assign acc_adj   = acc + (acc[AccW-1] ? AccW'(4095) : AccW'(0));
  assign corr_full = acc_adj >>> FracW;

  always_ff @(posedge clk) begin
    if (cmd.corr_en) begin
      if (corr_full > top_ext) begin
        corr <= $signed({1'b0, top_speed});
      end else if (corr_full < -top_ext) begin
        corr <= -$signed({1'b0, top_speed});
      end else begin
        corr <= corr_full[SpeedW:0];
      end
    end
  end

  assign flo_c = (floor_speed > top_speed) ? top_speed : floor_speed;
  assign rng   = top_speed - flo_c;
  assign sum_l = $signed({2'b00, top_speed}) + (SpeedW+2)'(corr);
  assign sum_r = $signed({2'b00, top_speed}) - (SpeedW+2)'(corr);
  assign s_l   = clamp_top(sum_l, top_speed);
  assign s_r   = clamp_top(sum_r, top_speed);

  always_ff @(posedge clk) begin
    if (cmd.speed_en) begin
      num_l <= rng * s_l;
      num_r <= rng * s_r;
    end
  end

  lfpd_div u_div_l (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (num_l),
    .divisor  (top_speed),
    .done     (done_l),
    .quotient (quo_l)
  );

  lfpd_div u_div_r (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (num_r),
    .divisor  (top_speed),
    .done     (done_r),
    .quotient (quo_r)
  );

  assign map_l = (top_speed == '0) ? '0 : flo_c + quo_l[SpeedW-1:0];
  assign map_r = (top_speed == '0) ? '0 : flo_c + quo_r[SpeedW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.slow_en) begin
      mapped_l <= map_l;
      mapped_r <= map_r;
      prod5_l  <= slow_prod(map_l, cw);
      prod5_r  <= slow_prod(map_r, cw);
    end
  end

  assign fin_l = slow_speed(prod5_l);
  assign fin_r = slow_speed(prod5_r);

  always_comb begin
    duty_l = mapped_l;
    duty_r = mapped_r;
    case (band)
      BAND_SLOW: begin
        duty_l = fin_l[SpeedW-1:0];
        duty_r = fin_r[SpeedW-1:0];
      end
      BAND_STOP: begin
        duty_l = '0;
        duty_r = '0;
      end
      default: begin
        duty_l = mapped_l;
        duty_r = mapped_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      left_duty     <= duty_l;
      right_duty    <= duty_r;
      left_forward  <= (duty_l != '0);
      right_forward <= (duty_r != '0);
    end
  end

  assign sts.in_valid = in_valid;
  assign sts.div_done = done_l && done_r;
  assign sts.out_free = !out_valid || !out_stall;

endmodule
